@@ design/ctcp_pkg.sv @@
package ctcp_pkg;

   // character codes
   typedef logic [15:0] char_type;

   localparam char_type MARKER_CHAR = 16'h0001;
   localparam char_type SPACE_CHAR  = 16'h0020;
   localparam char_type DLE_CHAR    = 16'h0010;

   // result kinds
   typedef logic [2:0] kind_type;

   localparam kind_type KIND_TEXT  = 3'd0;
   localparam kind_type KIND_KEY   = 3'd1;
   localparam kind_type KIND_PARAM = 3'd2;
   localparam kind_type KIND_NEWP  = 3'd3;
   localparam kind_type KIND_EOL   = 3'd4;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TEXT,
      ST_READ,
      ST_PROC,
      ST_END_DLE,
      ST_REL_MARK,
      ST_REL_READ,
      ST_REL_PROC,
      ST_EOL
   } state_type;

   // outcome of unquoting the character after a dle
   typedef struct packed {
      logic     hit;
      char_type value;
   } unescape_type;

   function automatic unescape_type unescape(input char_type c);
      unescape_type r;
      r.hit   = 1'b1;
      r.value = '0;
      case (c)
         16'h0030: r.value = 16'h0000;
         16'h0031: r.value = 16'h0001;
         16'h006E: r.value = 16'h000A;
         16'h0072: r.value = 16'h000D;
         16'h0040: r.value = 16'h0020;
         16'h0010: r.value = 16'h0010;
         default:  r.hit   = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ design/ctcp_if.sv @@
interface ctcp_req_if;
   import ctcp_pkg::*;

   logic     valid;
   logic     ready;
   char_type char_in;
   logic     line_last;

   modport source (output valid, output char_in, output line_last, input ready);
   modport sink (input valid, input char_in, input line_last, output ready);
endinterface

interface ctcp_rsp_if;
   import ctcp_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   char_type char_out;
   logic     event_last;
   logic     overflow;

   modport source (output valid, output kind, output char_out, output event_last,
                   output overflow, input ready);
   modport sink (input valid, input kind, input char_out, input event_last,
                 input overflow, output ready);
endinterface

@@ design/ctcp_message_extractor.sv @@
// channel   | port     | direction | carries
// ----------+----------+-----------+------------------------------------------
// request   | req_chan | in        | char_in, line_last
// response  | rsp_chan | out       | kind, char_out, event_last, overflow
//
// A plain text character passes through the text state; an opening marker or
// a buffered character is taken in idle. At a closing marker the body is
// drained from the body memory, each stored character by a read and then a
// step of the shared decode, plus another decode step for a kept dle; a line
// end release emits the marker, then drains the body the same way. The end of
// line result comes last. Reset is synchronous and clears the sequencer, body
// state and response valid only. A stalled response holds the sequencer.
module ctcp_message_extractor #(
   parameter int BODY_DEPTH = 60
) (
   input logic      clock,
   input logic      reset,
   ctcp_req_if.sink   req_chan,
   ctcp_rsp_if.source rsp_chan
);
   import ctcp_pkg::*;

   localparam int CNT_W = $clog2(BODY_DEPTH + 1);
   localparam int IDX_W = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;

   // body memory
   char_type body_mem [BODY_DEPTH];
   char_type rd_data_ff;

   state_type  state_ff, state_in;
   logic       inside_ff, inside_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic       body_ovf_ff, body_ovf_in;
   logic       param_ff, param_in;
   logic       pending_ff, pending_in;
   char_type   hold_char_ff, hold_char_in;
   logic       hold_last_ff, hold_last_in;

   logic       rsp_valid_ff, rsp_valid_in;
   kind_type   rsp_kind_ff, rsp_kind_in;
   char_type   rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_ovf_ff, rsp_ovf_in;

   logic       wr_en;
   logic       out_free;
   logic       emit;
   kind_type   em_kind;
   char_type   em_char;
   logic       em_last;
   logic       em_ovf;
   logic       final_char;
   logic [CNT_W-1:0] idx_next;
   unescape_type esc;

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign idx_next   = idx_ff + CNT_W'(1);
   assign final_char = (idx_next == count_ff);
   assign esc        = unescape(rd_data_ff);

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.char_out   = rsp_char_ff;
   assign rsp_chan.event_last = rsp_last_ff;
   assign rsp_chan.overflow   = rsp_ovf_ff;

   // sequencer and shared decode step
   always_comb begin
      state_in     = state_ff;
      inside_in    = inside_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      body_ovf_in  = body_ovf_ff;
      param_in     = param_ff;
      pending_in   = pending_ff;
      hold_char_in = hold_char_ff;
      hold_last_in = hold_last_ff;
      wr_en        = 1'b0;
      emit         = 1'b0;
      em_kind      = KIND_TEXT;
      em_char      = '0;
      em_last      = 1'b0;
      em_ovf       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               hold_char_in = req_chan.char_in;
               hold_last_in = req_chan.line_last;
               if (!inside_ff) begin
                  if (req_chan.char_in == MARKER_CHAR) begin
                     inside_in   = 1'b1;
                     count_in    = '0;
                     body_ovf_in = 1'b0;
                     state_in    = req_chan.line_last ? ST_REL_MARK : ST_IDLE;
                  end else begin
                     state_in = ST_TEXT;
                  end
               end else if (req_chan.char_in == MARKER_CHAR) begin
                  if (count_ff == '0) begin
                     inside_in   = 1'b0;
                     body_ovf_in = 1'b0;
                     state_in    = req_chan.line_last ? ST_EOL : ST_IDLE;
                  end else begin
                     idx_in     = '0;
                     param_in   = 1'b0;
                     pending_in = 1'b0;
                     state_in   = ST_READ;
                  end
               end else begin
                  if (count_ff < CNT_W'(BODY_DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end else begin
                     body_ovf_in = 1'b1;
                  end
                  state_in = req_chan.line_last ? ST_REL_MARK : ST_IDLE;
               end
            end
         end

         ST_TEXT: begin
            emit    = 1'b1;
            em_kind = KIND_TEXT;
            em_char = hold_char_ff;
            if (out_free) begin
               state_in = hold_last_ff ? ST_EOL : ST_IDLE;
            end
         end

         ST_READ: begin
            state_in = ST_PROC;
         end

         // one body character per step, a character after a kept dle twice: keyword, then parameters
         ST_PROC: begin
            em_ovf = body_ovf_ff;
            if (!param_ff) begin
               emit = 1'b1;
               if (rd_data_ff == SPACE_CHAR) begin
                  em_kind = KIND_NEWP;
               end else begin
                  em_kind = KIND_KEY;
                  em_char = rd_data_ff;
               end
               em_last = final_char;
               if (out_free) begin
                  if (rd_data_ff == SPACE_CHAR) begin
                     param_in = 1'b1;
                  end
                  if (final_char) begin
                     inside_in   = 1'b0;
                     count_in    = '0;
                     body_ovf_in = 1'b0;
                     state_in    = hold_last_ff ? ST_EOL : ST_IDLE;
                  end else begin
                     idx_in   = idx_next;
                     state_in = ST_READ;
                  end
               end
            end else if (pending_ff) begin
               emit    = 1'b1;
               em_kind = KIND_PARAM;
               if (esc.hit) begin
                  em_char = esc.value;
                  em_last = final_char;
                  if (out_free) begin
                     pending_in = 1'b0;
                     if (final_char) begin
                        inside_in   = 1'b0;
                        count_in    = '0;
                        body_ovf_in = 1'b0;
                        state_in    = hold_last_ff ? ST_EOL : ST_IDLE;
                     end else begin
                        idx_in   = idx_next;
                        state_in = ST_READ;
                     end
                  end
               end else begin
                  // dle kept as is, this character is decoded again
                  em_char = DLE_CHAR;
                  if (out_free) begin
                     pending_in = 1'b0;
                  end
               end
            end else if (rd_data_ff == DLE_CHAR) begin
               pending_in = 1'b1;
               if (final_char) begin
                  state_in = ST_END_DLE;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_READ;
               end
            end else begin
               emit = 1'b1;
               if (rd_data_ff == SPACE_CHAR) begin
                  em_kind = KIND_NEWP;
               end else begin
                  em_kind = KIND_PARAM;
                  em_char = rd_data_ff;
               end
               em_last = final_char;
               if (out_free) begin
                  if (final_char) begin
                     inside_in   = 1'b0;
                     count_in    = '0;
                     body_ovf_in = 1'b0;
                     state_in    = hold_last_ff ? ST_EOL : ST_IDLE;
                  end else begin
                     idx_in   = idx_next;
                     state_in = ST_READ;
                  end
               end
            end
         end

         // trailing dle of the body
         ST_END_DLE: begin
            emit    = 1'b1;
            em_kind = KIND_PARAM;
            em_char = DLE_CHAR;
            em_last = 1'b1;
            em_ovf  = body_ovf_ff;
            if (out_free) begin
               pending_in  = 1'b0;
               inside_in   = 1'b0;
               count_in    = '0;
               body_ovf_in = 1'b0;
               state_in    = hold_last_ff ? ST_EOL : ST_IDLE;
            end
         end

         // unclosed opener released as text
         ST_REL_MARK: begin
            emit    = 1'b1;
            em_kind = KIND_TEXT;
            em_char = MARKER_CHAR;
            em_ovf  = body_ovf_ff;
            if (out_free) begin
               if (count_ff == '0) begin
                  inside_in   = 1'b0;
                  body_ovf_in = 1'b0;
                  state_in    = ST_EOL;
               end else begin
                  idx_in   = '0;
                  state_in = ST_REL_READ;
               end
            end
         end

         ST_REL_READ: begin
            state_in = ST_REL_PROC;
         end

         ST_REL_PROC: begin
            emit    = 1'b1;
            em_kind = KIND_TEXT;
            em_char = rd_data_ff;
            em_ovf  = body_ovf_ff;
            if (out_free) begin
               if (final_char) begin
                  inside_in   = 1'b0;
                  count_in    = '0;
                  body_ovf_in = 1'b0;
                  state_in    = ST_EOL;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_REL_READ;
               end
            end
         end

         ST_EOL: begin
            emit    = 1'b1;
            em_kind = KIND_EOL;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (emit && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = em_kind;
         rsp_char_in  = em_char;
         rsp_last_in  = em_last;
         rsp_ovf_in   = em_ovf;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inside_ff    <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         body_ovf_ff  <= 1'b0;
         param_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         inside_ff    <= inside_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         body_ovf_ff  <= body_ovf_in;
         param_ff     <= param_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_char_ff <= hold_char_in;
      hold_last_ff <= hold_last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // body memory write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         body_mem[count_ff[IDX_W-1:0]] <= req_chan.char_in;
      end
      rd_data_ff <= body_mem[idx_ff[IDX_W-1:0]];
   end

endmodule
